/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition: label");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* rtl/core/fce_pkg.sv */
// ----------------------------------------------------------------------------
// fce_pkg
// Types, opcodes and coefficient helpers of the effect command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fce_pkg;

   typedef enum logic [2:0] {
      OP_CONSTANT = 3'd0,
      OP_SPRING   = 3'd1,
      OP_DAMPER   = 3'd2,
      OP_FRICTION = 3'd3,
      OP_STOP     = 3'd4
   } fce_op_type;

   localparam logic [7:0] CMD_CONSTANT      = 8'h11;
   localparam logic [7:0] CMD_SPRING        = 8'h21;
   localparam logic [7:0] CMD_SPRING_STOP   = 8'h23;
   localparam logic [7:0] CMD_DAMPER        = 8'h41;
   localparam logic [7:0] CMD_DAMPER_STOP   = 8'h43;
   localparam logic [7:0] CMD_FRICTION      = 8'h81;
   localparam logic [7:0] CMD_FRICTION_STOP = 8'h83;
   localparam logic [7:0] TYPE_SPRING       = 8'h0b;
   localparam logic [7:0] TYPE_DAMPER       = 8'h0c;
   localparam logic [7:0] TYPE_FRICTION     = 8'h0e;
   localparam logic [3:0] STOP_LOW_BITS     = 4'h3;
   localparam logic [15:0] COEF_OFFSET      = 16'd2048;
   localparam logic [10:0] BOUND_OPEN_RIGHT = 11'd2047;
   localparam int unsigned NUM_BYTES        = 7;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] force_req;
      logic signed [15:0] left_bound;
      logic signed [15:0] right_bound;
      logic signed [15:0] left_coef;
      logic signed [15:0] right_coef;
      logic [15:0]        clip_level;
      logic [2:0]         slot_index;
   } fce_req_type;

   typedef struct packed {
      logic [NUM_BYTES-1:0][7:0] cmd_byte;
      logic                      bad_request;
   } fce_cmd_type;

   function automatic logic [15:0] coef_mag(input logic [15:0] v);
      coef_mag = v[15] ? 16'(~v + 16'd1) : v;
   endfunction

   function automatic logic [3:0] code4(input logic [15:0] m);
      code4 = m[15] ? 4'hF : m[14:11];
   endfunction

   function automatic logic [7:0] code8(input logic [15:0] m);
      code8 = m[15] ? 8'hFF : m[14:7];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/fce_encode.sv */
// ----------------------------------------------------------------------------
// fce_encode
// Combinational encoding of one registered request into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_encode
   import fce_pkg::*;
(
   input  fce_req_type req,
   output fce_cmd_type cmd
);

   logic [15:0] lc_mag;
   logic [15:0] rc_mag;
   logic        lc_neg;
   logic        rc_neg;
   logic        clip_zero;
   logic        bound_rev;
   logic        lc_open;
   logic        rc_open;
   logic [15:0] k1;
   logic [15:0] k2;
   logic [10:0] d1;
   logic [10:0] d2;
   logic [3:0]  slot_hot;

   assign lc_mag    = coef_mag(req.left_coef);
   assign rc_mag    = coef_mag(req.right_coef);
   assign lc_neg    = req.left_coef[15];
   assign rc_neg    = req.right_coef[15];
   assign clip_zero = (req.clip_level == 16'd0);
   assign bound_rev = ($signed(req.left_bound) > $signed(req.right_bound));
   assign lc_open   = (lc_mag < COEF_OFFSET);
   assign rc_open   = (rc_mag < COEF_OFFSET);
   assign k1        = lc_open ? lc_mag : 16'(lc_mag - COEF_OFFSET);
   assign k2        = rc_open ? rc_mag : 16'(rc_mag - COEF_OFFSET);
   assign d1        = lc_open ? 11'd0 : {~req.left_bound[15], req.left_bound[14:5]};
   assign d2        = rc_open ? BOUND_OPEN_RIGHT : {~req.right_bound[15], req.right_bound[14:5]};
   assign slot_hot  = 4'(4'd1 << req.slot_index[1:0]);

   always_comb begin
      cmd = '0;
      case (fce_op_type'(req.op))
         OP_CONSTANT: begin
            cmd.cmd_byte[0] = CMD_CONSTANT;
            cmd.cmd_byte[2] = {~req.force_req[15], req.force_req[14:8]};
         end
         OP_SPRING: begin
            if (bound_rev) begin
               cmd.bad_request = 1'b1;
            end else if (clip_zero) begin
               cmd.cmd_byte[0] = CMD_SPRING_STOP;
            end else begin
               cmd.cmd_byte[0] = CMD_SPRING;
               cmd.cmd_byte[1] = TYPE_SPRING;
               cmd.cmd_byte[2] = d1[10:3];
               cmd.cmd_byte[3] = d2[10:3];
               cmd.cmd_byte[4] = {code4(k2), code4(k1)};
               cmd.cmd_byte[5] = {d2[2:0], rc_neg, d1[2:0], lc_neg};
               cmd.cmd_byte[6] = req.clip_level[15:8];
            end
         end
         OP_DAMPER: begin
            if (clip_zero) begin
               cmd.cmd_byte[0] = CMD_DAMPER_STOP;
            end else begin
               cmd.cmd_byte[0] = CMD_DAMPER;
               cmd.cmd_byte[1] = TYPE_DAMPER;
               cmd.cmd_byte[2] = {4'd0, code4(lc_mag)};
               cmd.cmd_byte[3] = {7'd0, lc_neg};
               cmd.cmd_byte[4] = {4'd0, code4(rc_mag)};
               cmd.cmd_byte[5] = {7'd0, rc_neg};
               cmd.cmd_byte[6] = req.clip_level[15:8];
            end
         end
         OP_FRICTION: begin
            if (clip_zero) begin
               cmd.cmd_byte[0] = CMD_FRICTION_STOP;
            end else begin
               cmd.cmd_byte[0] = CMD_FRICTION;
               cmd.cmd_byte[1] = TYPE_FRICTION;
               cmd.cmd_byte[2] = code8(lc_mag);
               cmd.cmd_byte[3] = code8(rc_mag);
               cmd.cmd_byte[4] = req.clip_level[15:8];
               cmd.cmd_byte[5] = {3'd0, rc_neg, 3'd0, lc_neg};
            end
         end
         OP_STOP: begin
            if (req.slot_index[2]) begin
               cmd.bad_request = 1'b1;
            end else begin
               cmd.cmd_byte[0] = {slot_hot, STOP_LOW_BITS};
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/ffb_effect_command_encoder.sv */
// ----------------------------------------------------------------------------
// ffb_effect_command_encoder
// Encodes force-feedback effect requests into seven-byte wheel commands.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one effect request per beat; a beat is taken
//   at a rising edge with req_valid high and req_stall low. The rsp_ channel
//   returns one command beat per request, in order, with bytes 0 to 6 and
//   the bad_request flag.
//   Path: a taken request passes the input register, the encode logic and
//   the output register before it is shown on rsp_.
//   Throughput: one request per cycle while rsp_stall is low, set by the
//   single encode stage between the two registers.
//   Stall: while rsp_stall holds a result, the output register keeps it and
//   the input register still takes one more request; req_stall rises only
//   when both registers are full and the result is not taken.
//   Reset: synchronous, active high; both registers are emptied and no
//   beat is offered on rsp_ until new requests arrive.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffb_effect_command_encoder
   import fce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic signed [15:0] req_force_req,
   input  wire logic signed [15:0] req_left_bound,
   input  wire logic signed [15:0] req_right_bound,
   input  wire logic signed [15:0] req_left_coef,
   input  wire logic signed [15:0] req_right_coef,
   input  wire logic [15:0]        req_clip_level,
   input  wire logic [2:0]         req_slot_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [7:0]         rsp_cmd_byte0,
   output      logic [7:0]         rsp_cmd_byte1,
   output      logic [7:0]         rsp_cmd_byte2,
   output      logic [7:0]         rsp_cmd_byte3,
   output      logic [7:0]         rsp_cmd_byte4,
   output      logic [7:0]         rsp_cmd_byte5,
   output      logic [7:0]         rsp_cmd_byte6,
   output      logic               rsp_bad_request
);

   fce_req_type req_in;
   fce_req_type req_ff;
   logic        req_valid_in;
   logic        req_valid_ff;
   fce_cmd_type cmd_in;
   fce_cmd_type cmd_ff;
   logic        rsp_valid_in;
   logic        rsp_valid_ff;
   logic        out_load;
   logic        in_load;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !out_load;
   assign in_load = !req_stall;

   assign req_in = '{op:          req_op,
                     force_req:   req_force_req,
                     left_bound:  req_left_bound,
                     right_bound: req_right_bound,
                     left_coef:   req_left_coef,
                     right_coef:  req_right_coef,
                     clip_level:  req_clip_level,
                     slot_index:  req_slot_index};

   assign req_valid_in = in_load ? req_valid : req_valid_ff;
   assign rsp_valid_in = out_load ? req_valid_ff : rsp_valid_ff;

   fce_encode u_encode (
      .req (req_ff),
      .cmd (cmd_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         req_ff <= req_in;
      end
      if (out_load) begin
         cmd_ff <= cmd_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cmd_byte0   = cmd_ff.cmd_byte[0];
   assign rsp_cmd_byte1   = cmd_ff.cmd_byte[1];
   assign rsp_cmd_byte2   = cmd_ff.cmd_byte[2];
   assign rsp_cmd_byte3   = cmd_ff.cmd_byte[3];
   assign rsp_cmd_byte4   = cmd_ff.cmd_byte[4];
   assign rsp_cmd_byte5   = cmd_ff.cmd_byte[5];
   assign rsp_cmd_byte6   = cmd_ff.cmd_byte[6];
   assign rsp_bad_request = cmd_ff.bad_request;

   `ASSERT_NEVER(a_bad_bytes_zero, clock, reset,
      rsp_valid_ff && cmd_ff.bad_request && (cmd_ff.cmd_byte != '0))
   `ASSERT_PROP(a_held_item_kept, clock, reset,
      (req_valid_ff && !out_load) |=> req_valid_ff)
   `ASSERT_PROP(a_moved_item_shown, clock, reset,
      (req_valid_ff && out_load) |=> rsp_valid_ff)
   `ASSERT_PROP(a_drained_when_idle, clock, reset,
      (!req_valid_ff && out_load) |=> !rsp_valid_ff)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the effect command encoder: a queue-fed driver
// sends effect requests, a built-in encoder predicts each seven-byte command,
// and a monitor compares every result beat byte by byte in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import fce_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int         EFFECT_ITEMS = 850;
   localparam int         PRINT_LIMIT  = 50;

   typedef struct {
      fce_req_type req;
      bit          drain;
   } pending_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_op = '0;
   logic signed [15:0] req_force_req = '0;
   logic signed [15:0] req_left_bound = '0;
   logic signed [15:0] req_right_bound = '0;
   logic signed [15:0] req_left_coef = '0;
   logic signed [15:0] req_right_coef = '0;
   logic [15:0]        req_clip_level = '0;
   logic [2:0]         req_slot_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_cmd_byte0;
   logic [7:0]         rsp_cmd_byte1;
   logic [7:0]         rsp_cmd_byte2;
   logic [7:0]         rsp_cmd_byte3;
   logic [7:0]         rsp_cmd_byte4;
   logic [7:0]         rsp_cmd_byte5;
   logic [7:0]         rsp_cmd_byte6;
   logic               rsp_bad_request;

   pending_type request_q[$];
   fce_cmd_type cmd_expect_q[$];
   int          error_cnt = 0;
   int          accepted_cnt = 0;
   int          result_cnt = 0;
   int          total_items = 0;
   int          send_idle_pct = 18;
   int          recv_idle_pct = 57;
   bit          req_taken = 1'b0;

   ffb_effect_command_encoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_force_req   (req_force_req),
      .req_left_bound  (req_left_bound),
      .req_right_bound (req_right_bound),
      .req_left_coef   (req_left_coef),
      .req_right_coef  (req_right_coef),
      .req_clip_level  (req_clip_level),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cmd_byte0   (rsp_cmd_byte0),
      .rsp_cmd_byte1   (rsp_cmd_byte1),
      .rsp_cmd_byte2   (rsp_cmd_byte2),
      .rsp_cmd_byte3   (rsp_cmd_byte3),
      .rsp_cmd_byte4   (rsp_cmd_byte4),
      .rsp_cmd_byte5   (rsp_cmd_byte5),
      .rsp_cmd_byte6   (rsp_cmd_byte6),
      .rsp_bad_request (rsp_bad_request)
   );

   always #4 clock = ~clock;

   function automatic int unsigned sat_code(input int unsigned m, input int shift);
      int unsigned d;
      d = m * 2;
      if (d > 65535) d = 65535;
      return d >> shift;
   endfunction

   function automatic int unsigned abs_coef(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic fce_cmd_type encode_effect(input fce_req_type r);
      fce_cmd_type c;
      int          fr, lb, rb, lc, rc;
      int unsigned d1, d2, k1, k2, sg;
      logic [7:0]  hi_clip;
      c = '0;
      fr = $signed(r.force_req);
      lb = $signed(r.left_bound);
      rb = $signed(r.right_bound);
      lc = $signed(r.left_coef);
      rc = $signed(r.right_coef);
      hi_clip = r.clip_level[15:8];
      sg = ((lc < 0) ? 1 : 0) | ((rc < 0) ? 16 : 0);
      case (r.op)
         OP_CONSTANT: begin
            c.cmd_byte[0] = CMD_CONSTANT;
            c.cmd_byte[2] = 8'((fr + 32768) >> 8);
         end
         OP_SPRING: begin
            if (lb > rb) begin
               c.bad_request = 1'b1;
            end else if (r.clip_level == 0) begin
               c.cmd_byte[0] = CMD_SPRING_STOP;
            end else begin
               d1 = (lb + 32768) >> 5;
               d2 = (rb + 32768) >> 5;
               k1 = abs_coef(lc);
               k2 = abs_coef(rc);
               if (k1 < COEF_OFFSET) d1 = 0;
               else k1 -= COEF_OFFSET;
               if (k2 < COEF_OFFSET) d2 = BOUND_OPEN_RIGHT;
               else k2 -= COEF_OFFSET;
               c.cmd_byte[0] = CMD_SPRING;
               c.cmd_byte[1] = TYPE_SPRING;
               c.cmd_byte[2] = 8'(d1 >> 3);
               c.cmd_byte[3] = 8'(d2 >> 3);
               c.cmd_byte[4] = 8'((sat_code(k2, 12) << 4) | sat_code(k1, 12));
               c.cmd_byte[5] = 8'(((d2 & 7) << 5) | ((d1 & 7) << 1) | sg);
               c.cmd_byte[6] = hi_clip;
            end
         end
         OP_DAMPER: begin
            if (r.clip_level == 0) begin
               c.cmd_byte[0] = CMD_DAMPER_STOP;
            end else begin
               c.cmd_byte[0] = CMD_DAMPER;
               c.cmd_byte[1] = TYPE_DAMPER;
               c.cmd_byte[2] = 8'(sat_code(abs_coef(lc), 12));
               c.cmd_byte[3] = (lc < 0) ? 8'd1 : 8'd0;
               c.cmd_byte[4] = 8'(sat_code(abs_coef(rc), 12));
               c.cmd_byte[5] = (rc < 0) ? 8'd1 : 8'd0;
               c.cmd_byte[6] = hi_clip;
            end
         end
         OP_FRICTION: begin
            if (r.clip_level == 0) begin
               c.cmd_byte[0] = CMD_FRICTION_STOP;
            end else begin
               c.cmd_byte[0] = CMD_FRICTION;
               c.cmd_byte[1] = TYPE_FRICTION;
               c.cmd_byte[2] = 8'(sat_code(abs_coef(lc), 8));
               c.cmd_byte[3] = 8'(sat_code(abs_coef(rc), 8));
               c.cmd_byte[4] = hi_clip;
               c.cmd_byte[5] = 8'(sg);
            end
         end
         OP_STOP: begin
            if (r.slot_index > 3) c.bad_request = 1'b1;
            else c.cmd_byte[0] = 8'((1 << (r.slot_index + 4)) | STOP_LOW_BITS);
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_coef();
      int v;
      if ($urandom_range(0, 9) < 4) begin
         v = $urandom_range(0, 4400);
         return 16'(v - 2200);
      end
      return pick_word();
   endfunction

   function automatic pending_type random_request();
      pending_type p;
      logic [15:0] a, b, t;
      int          sel;
      p.drain = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 18) p.req.op = OP_CONSTANT;
      else if (sel < 38) p.req.op = OP_SPRING;
      else if (sel < 58) p.req.op = OP_DAMPER;
      else if (sel < 76) p.req.op = OP_FRICTION;
      else if (sel < 94) p.req.op = OP_STOP;
      else p.req.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      a = pick_word();
      b = pick_word();
      if ($urandom_range(0, 99) < 85 && $signed(a) > $signed(b)) begin
         t = a;
         a = b;
         b = t;
      end
      p.req.force_req = pick_word();
      p.req.left_bound = a;
      p.req.right_bound = b;
      p.req.left_coef = pick_coef();
      p.req.right_coef = pick_coef();
      case ($urandom_range(0, 9))
         0: p.req.clip_level = 16'h0000;
         1: p.req.clip_level = 16'hFFFF;
         default: p.req.clip_level = pick_word();
      endcase
      if (p.req.op == OP_STOP && $urandom_range(0, 99) < 80)
         p.req.slot_index = 3'($urandom_range(0, 3));
      else
         p.req.slot_index = 3'($urandom_range(0, 7));
      return p;
   endfunction

   task automatic add_request(input logic [2:0] op, input logic [15:0] fr, lb, rb, lc, rc,
                              input logic [15:0] clip, input logic [2:0] slot);
      pending_type p;
      p.drain = 1'b0;
      p.req.op = op;
      p.req.force_req = fr;
      p.req.left_bound = lb;
      p.req.right_bound = rb;
      p.req.left_coef = lc;
      p.req.right_coef = rc;
      p.req.clip_level = clip;
      p.req.slot_index = slot;
      request_q.push_back(p);
   endtask

   task automatic report_mismatch(input string msg);
      if (error_cnt < PRINT_LIMIT) $display("MISMATCH %0t: %s", $time, msg);
      error_cnt++;
   endtask

   // driver: present the next beat at the falling edge
   always @(negedge clock) begin
      pending_type nxt;
      bit          launch;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            launch = request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (launch && request_q[0].drain && cmd_expect_q.size() != 0) launch = 1'b0;
            if (launch) begin
               nxt = request_q.pop_front();
               req_op <= nxt.req.op;
               req_force_req <= nxt.req.force_req;
               req_left_bound <= nxt.req.left_bound;
               req_right_bound <= nxt.req.right_bound;
               req_left_coef <= nxt.req.left_coef;
               req_right_coef <= nxt.req.right_coef;
               req_clip_level <= nxt.req.clip_level;
               req_slot_index <= nxt.req.slot_index;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      req_taken = 1'b0;
   end

   // monitor: check result beats, then record accepted requests
   always @(posedge clock) begin
      fce_cmd_type want, got;
      fce_req_type cur;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.cmd_byte[0] = rsp_cmd_byte0;
            got.cmd_byte[1] = rsp_cmd_byte1;
            got.cmd_byte[2] = rsp_cmd_byte2;
            got.cmd_byte[3] = rsp_cmd_byte3;
            got.cmd_byte[4] = rsp_cmd_byte4;
            got.cmd_byte[5] = rsp_cmd_byte5;
            got.cmd_byte[6] = rsp_cmd_byte6;
            got.bad_request = rsp_bad_request;
            if (cmd_expect_q.size() == 0) begin
               report_mismatch("result beat with no command expected");
            end else begin
               want = cmd_expect_q.pop_front();
               for (int i = 0; i < NUM_BYTES; i++)
                  if (got.cmd_byte[i] !== want.cmd_byte[i])
                     report_mismatch($sformatf("beat %0d cmd_byte%0d got %02h want %02h",
                                               result_cnt, i, got.cmd_byte[i],
                                               want.cmd_byte[i]));
               if (got.bad_request !== want.bad_request)
                  report_mismatch($sformatf("beat %0d bad_request got %b want %b",
                                            result_cnt, got.bad_request, want.bad_request));
            end
            result_cnt++;
         end
         if (req_valid && !req_stall) begin
            cur.op = req_op;
            cur.force_req = req_force_req;
            cur.left_bound = req_left_bound;
            cur.right_bound = req_right_bound;
            cur.left_coef = req_left_coef;
            cur.right_coef = req_right_coef;
            cur.clip_level = req_clip_level;
            cur.slot_index = req_slot_index;
            cmd_expect_q.push_back(encode_effect(cur));
            req_taken = 1'b1;
            accepted_cnt++;
            if (accepted_cnt >= 2 * total_items / 3) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end else if (accepted_cnt >= total_items / 3) begin
               send_idle_pct = 57;
               recv_idle_pct = 18;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      pending_type p;
      int          counted;
      // constant force extremes
      add_request(OP_CONSTANT, 16'h8000, 0, 0, 0, 0, 16'hFFFF, 0);
      add_request(OP_CONSTANT, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 7);
      add_request(OP_CONSTANT, 16'h0000, 0, 0, 0, 0, 16'h1234, 0);
      // spring: full span, saturated coefficients of both signs
      add_request(OP_SPRING, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
      add_request(OP_SPRING, 0, 16'hF000, 16'h1000, 16'h7FFF, 16'h8000, 16'h00FF, 0);
      // spring: open deadband on both sides, then coefficients at the edge
      add_request(OP_SPRING, 0, 16'hC000, 16'h4000, 16'd2047, 16'hF801, 16'h8000, 0);
      add_request(OP_SPRING, 0, 16'hC000, 16'h4000, 16'd2048, 16'hF800, 16'h8000, 0);
      add_request(OP_SPRING, 0, 16'h1234, 16'h1234, 16'd0, 16'hFFFF, 16'h0100, 0);
      // spring: zero clip, reversed bounds with and without clip
      add_request(OP_SPRING, 0, 16'h0000, 16'h0100, 16'h4000, 16'h4000, 16'h0000, 0);
      add_request(OP_SPRING, 0, 16'h7FFF, 16'h8000, 16'h4000, 16'h4000, 16'hFFFF, 0);
      add_request(OP_SPRING, 0, 16'h0001, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 0);
      // damper
      add_request(OP_DAMPER, 0, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
      add_request(OP_DAMPER, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h0001, 0);
      add_request(OP_DAMPER, 0, 0, 0, 16'h4000, 16'h4000, 16'h0000, 0);
      // friction
      add_request(OP_FRICTION, 0, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
      add_request(OP_FRICTION, 0, 0, 0, 16'hFFFF, 16'h0080, 16'h0300, 0);
      add_request(OP_FRICTION, 0, 0, 0, 16'h4000, 16'h4000, 16'h0000, 0);
      // stop every slot, plus slots out of range
      for (int s = 0; s < 4; s++) add_request(OP_STOP, 0, 0, 0, 0, 0, 16'hFFFF, 3'(s));
      add_request(OP_STOP, 0, 0, 0, 0, 0, 16'hFFFF, 4);
      add_request(OP_STOP, 0, 0, 0, 0, 0, 16'hFFFF, 7);
      // unused opcodes
      add_request(OP_UNUSED_LO, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 7);
      add_request(OP_UNUSED_HI, 16'h8000, 0, 0, 0, 0, 16'hFFFF, 0);

      counted = 0;
      while (counted < EFFECT_ITEMS) begin
         p = random_request();
         if (p.req.op <= OP_STOP) counted++;
         // hold off until every outstanding command has come back
         if (counted == 300 || counted == 600) p.drain = 1'b1;
         request_q.push_back(p);
      end
      total_items = request_q.size();

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_valid) @(negedge clock);
      while (cmd_expect_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (error_cnt == 0 && cmd_expect_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
